// File: hw/rtl/fk3_pkg.sv
// ----------------------------------------------------------------------------
// fk3_pkg: shared types, constants and helpers
// Widths, CORDIC arctangent table and saturation for the 3-axis arm kinematics.
// ----------------------------------------------------------------------------
package fk3_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANG_W         = 17;
    localparam int POS_W         = 19;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 8;
    localparam int CW            = 34;   // CORDIC datapath width
    localparam int STG_W         = 5;    // stage index width (up to 32 stages)
    localparam int TURN          = 36000;

    // floor(2^48 / 36000)
    localparam logic [32:0] BAM_RECIP = 33'd7818749353;
    // 0.6072529350 in Q30
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [POS_W-1:0] POS_MAX = 19'sd262143;
    localparam logic signed [POS_W-1:0] POS_MIN = -19'sd262144;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_OFFSET  = 8'd0,
        REG_UPPER_ARM    = 8'd1,
        REG_ELBOW_OFFSET = 8'd2,
        REG_FOREARM      = 8'd3
    } t_cfg_idx;

    typedef logic signed [CW-1:0] t_cw;

    // atan(2^-i) in binary-angle units (full turn = 2^32)
    localparam logic [31:0] ATAN_BAM [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // clamp a wide signed value to the position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [47:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 48'(POS_MAX))
            r = POS_MAX;
        else if (v < 48'(POS_MIN))
            r = POS_MIN;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/fk3_bam.sv
// ----------------------------------------------------------------------------
// fk3_bam: angle to CORDIC start angle
// Reduces hundredths of a degree modulo one turn, scales to a 32-bit binary
// angle with rounding and folds quadrants 1 and 2 onto the right half plane.
// Three pipeline stages.
// ----------------------------------------------------------------------------
module fk3_bam (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [17:0]        i_angle,
    output fk3_pkg::t_cw              o_z,
    output logic                      o_flip
);

    logic [15:0]  r_m,  n_m;
    logic [31:0]  r_q0, n_q0;
    logic [18:0]  w_off;
    logic [48:0]  w_prod;
    logic [17:0]  w_rem;
    logic [31:0]  w_t;
    logic [31:0]  w_tf;
    fk3_pkg::t_cw r_z;
    logic         r_flip;

    // stage 0: modulo one turn (offset by four turns, pick largest multiple)
    always_comb begin
        w_off = 19'($signed({i_angle[17], i_angle}) + 19'sd144000);
        n_m   = w_off[15:0];
        for (int k = 1; k < 8; k++) begin
            if (w_off >= 19'(k * fk3_pkg::TURN))
                n_m = 16'(w_off - 19'(k * fk3_pkg::TURN));
        end
    end

    // stage 1: reciprocal multiply, estimate is low by at most two
    assign w_prod = {33'd0, r_m} * {16'd0, fk3_pkg::BAM_RECIP};
    assign n_q0   = w_prod[47:16];

    // stage 2: remainder from low bits only, then quadrant fold
    always_comb begin
        w_rem = 18'(18'd18000 - 18'(r_q0[17:0] * 18'd36000));
        if (w_rem >= 18'd72000)
            w_t = r_q0 + 32'd2;
        else if (w_rem >= 18'd36000)
            w_t = r_q0 + 32'd1;
        else
            w_t = r_q0;
        w_tf = (w_t[31] ^ w_t[30]) ? (w_t + 32'h8000_0000) : w_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_m;
            r_q0   <= n_q0;
            r_z    <= fk3_pkg::CW'($signed(w_tf));
            r_flip <= w_t[31] ^ w_t[30];
        end
    end

    assign o_z    = r_z;
    assign o_flip = r_flip;

endmodule

// File: hw/rtl/fk3_cell.sv
// ----------------------------------------------------------------------------
// fk3_cell: one CORDIC rotation cell
// Rotates (x, y) by +-atan(2^-stage) toward z = 0 and passes the result on.
// ----------------------------------------------------------------------------
module fk3_cell (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [fk3_pkg::STG_W-1:0]      i_stage,
    input  fk3_pkg::t_cw                   i_x,
    input  fk3_pkg::t_cw                   i_y,
    input  fk3_pkg::t_cw                   i_z,
    input  logic                           i_flip,
    output fk3_pkg::t_cw                   o_x,
    output fk3_pkg::t_cw                   o_y,
    output fk3_pkg::t_cw                   o_z,
    output logic                           o_flip
);

    fk3_pkg::t_cw r_x, r_y, r_z, n_x, n_y, n_z;
    fk3_pkg::t_cw w_xs, w_ys, w_at;
    logic         r_flip;

    // micro-rotation, direction from the sign of the residual angle
    always_comb begin
        w_xs = i_x >>> i_stage;
        w_ys = i_y >>> i_stage;
        w_at = fk3_pkg::CW'(fk3_pkg::ATAN_BAM[i_stage]);
        if (!i_z[fk3_pkg::CW-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - w_at;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_flip <= i_flip;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_flip = r_flip;

endmodule

// File: hw/rtl/fk3_post.sv
// ----------------------------------------------------------------------------
// fk3_post: link geometry and base rotation
// Applies quadrant sign, forms reach and height from the link lengths, rotates
// the reach about the base axis and saturates. Five pipeline stages.
// ----------------------------------------------------------------------------
module fk3_post (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [fk3_pkg::CFG_W-1:0]         i_a1,
    input  logic [fk3_pkg::CFG_W-1:0]         i_a2,
    input  logic [fk3_pkg::CFG_W-1:0]         i_a3,
    input  logic [fk3_pkg::CFG_W-1:0]         i_d4,
    input  fk3_pkg::t_cw                      i_x [3],
    input  fk3_pkg::t_cw                      i_y [3],
    input  logic                              i_flip [3],
    output logic signed [fk3_pkg::POS_W-1:0]  o_pos_x,
    output logic signed [fk3_pkg::POS_W-1:0]  o_pos_y,
    output logic signed [fk3_pkg::POS_W-1:0]  o_pos_z
);

    // lane 0 base, lane 1 shoulder, lane 2 shoulder plus elbow
    fk3_pkg::t_cw        r_c [3];
    fk3_pkg::t_cw        r_s [3];
    fk3_pkg::t_cw        r1_cs, r1_ss, r2_cs, r2_ss;
    logic signed [46:0]  r_a3c23, r_d4s23, r_a2c2, r_a3s23, r_d4c23, r_a2s2;
    logic signed [48:0]  w_rq, w_zq;
    logic signed [34:0]  r_r16;
    logic signed [fk3_pkg::POS_W-1:0] r_z2, r_z3;
    logic signed [68:0]  r_px, r_py;
    logic signed [26:0]  w_xr, w_yr;
    logic signed [22:0]  w_zr;
    logic signed [fk3_pkg::POS_W-1:0] r_pos_x, r_pos_y, r_pos_z;

    // reach and height sums
    always_comb begin
        w_rq = 49'(r_a3c23) - 49'(r_d4s23) + 49'(r_a2c2)
             + $signed({7'd0, i_a1, 30'd0});
        w_zq = -49'(r_a3s23) - 49'(r_d4c23) - 49'(r_a2s2);
        w_zr = 23'((w_zq + 49'sd33554432) >>> 26);
        w_xr = 27'((r_px + 69'sd2199023255552) >>> 42);
        w_yr = 27'((r_py + 69'sd2199023255552) >>> 42);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // quadrant sign
            for (int j = 0; j < 3; j++) begin
                r_c[j] <= i_flip[j] ? -i_x[j] : i_x[j];
                r_s[j] <= i_flip[j] ? -i_y[j] : i_y[j];
            end
            // link products
            r_a3c23 <= $signed({1'b0, i_a3}) * r_c[2];
            r_d4s23 <= $signed({1'b0, i_d4}) * r_s[2];
            r_a2c2  <= $signed({1'b0, i_a2}) * r_c[1];
            r_a3s23 <= $signed({1'b0, i_a3}) * r_s[2];
            r_d4c23 <= $signed({1'b0, i_d4}) * r_c[2];
            r_a2s2  <= $signed({1'b0, i_a2}) * r_s[1];
            r1_cs   <= r_c[0];
            r1_ss   <= r_s[0];
            // reach in Q16, height rounded and clamped
            r_r16   <= 35'((w_rq + 49'sd8192) >>> 14);
            r_z2    <= fk3_pkg::sat_pos(48'(w_zr));
            r2_cs   <= r1_cs;
            r2_ss   <= r1_ss;
            // base rotation
            r_px    <= 69'(r2_cs) * 69'(r_r16);
            r_py    <= 69'(r2_ss) * 69'(r_r16);
            r_z3    <= r_z2;
            // output register
            r_pos_x <= fk3_pkg::sat_pos(48'(w_xr));
            r_pos_y <= fk3_pkg::sat_pos(48'(w_yr));
            r_pos_z <= r_z3;
        end
    end

    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;
    assign o_pos_z = r_pos_z;

endmodule

// File: hw/rtl/arm_forward_kinematics_3axis.sv
// ----------------------------------------------------------------------------
// arm_forward_kinematics_3axis: tool position of a 3-axis articulated arm
// Joint angles in hundredths of a degree in, x/y/z in 1/16 mm out.
// ----------------------------------------------------------------------------
// One joint-angle triple is accepted every clock cycle while the output is not
// stalled, and its position passes through angle scaling, one CORDIC cell per
// stage for each of the three angles, and link products, base rotation and
// saturation. The whole pipeline holds while a finished item waits at the
// output. Link lengths must be written through the configuration port only
// while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_3axis (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [fk3_pkg::ANG_W-1:0]   i_base_angle,
    input  logic signed [fk3_pkg::ANG_W-1:0]   i_shoulder_angle,
    input  logic signed [fk3_pkg::ANG_W-1:0]   i_elbow_angle,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [fk3_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [fk3_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [fk3_pkg::POS_W-1:0]   o_pos_z,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fk3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fk3_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int DEPTH = 3 + fk3_pkg::CORDIC_STAGES + 5;

    logic [DEPTH-1:0]          r_vld;
    logic                      w_en;
    logic [fk3_pkg::CFG_W-1:0] r_a1, r_a2, r_a3, r_d4;
    logic signed [17:0]        w_ang [3];
    fk3_pkg::t_cw              w_x [3][fk3_pkg::CORDIC_STAGES+1];
    fk3_pkg::t_cw              w_y [3][fk3_pkg::CORDIC_STAGES+1];
    fk3_pkg::t_cw              w_z [3][fk3_pkg::CORDIC_STAGES+1];
    logic                      w_f [3][fk3_pkg::CORDIC_STAGES+1];
    fk3_pkg::t_cw              w_xo [3];
    fk3_pkg::t_cw              w_yo [3];
    logic                      w_fo [3];

    // global advance: move unless the output item is stalled
    assign w_en        = !r_vld[DEPTH-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[DEPTH-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    // link length registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= 12'd150;
            r_a2 <= 12'd570;
            r_a3 <= 12'd130;
            r_d4 <= 12'd640;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fk3_pkg::REG_BASE_OFFSET:  r_a1 <= i_cfg_data;
                fk3_pkg::REG_UPPER_ARM:    r_a2 <= i_cfg_data;
                fk3_pkg::REG_ELBOW_OFFSET: r_a3 <= i_cfg_data;
                fk3_pkg::REG_FOREARM:      r_d4 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // three angle lanes: base, shoulder, shoulder plus elbow
    assign w_ang[0] = 18'(i_base_angle);
    assign w_ang[1] = 18'(i_shoulder_angle);
    assign w_ang[2] = 18'(i_shoulder_angle) + 18'(i_elbow_angle);

    for (genvar l = 0; l < 3; l++) begin : g_lane
        fk3_bam u_bam (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (w_ang[l]),
            .o_z     (w_z[l][0]),
            .o_flip  (w_f[l][0])
        );
        assign w_x[l][0] = fk3_pkg::CORDIC_GAIN;
        assign w_y[l][0] = '0;

        for (genvar g = 0; g < fk3_pkg::CORDIC_STAGES; g++) begin : g_cell
            fk3_cell u_cell (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_stage (fk3_pkg::STG_W'(g)),
                .i_x     (w_x[l][g]),
                .i_y     (w_y[l][g]),
                .i_z     (w_z[l][g]),
                .i_flip  (w_f[l][g]),
                .o_x     (w_x[l][g+1]),
                .o_y     (w_y[l][g+1]),
                .o_z     (w_z[l][g+1]),
                .o_flip  (w_f[l][g+1])
            );
        end

        assign w_xo[l] = w_x[l][fk3_pkg::CORDIC_STAGES];
        assign w_yo[l] = w_y[l][fk3_pkg::CORDIC_STAGES];
        assign w_fo[l] = w_f[l][fk3_pkg::CORDIC_STAGES];
    end

    fk3_post u_post (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_a1    (r_a1),
        .i_a2    (r_a2),
        .i_a3    (r_a3),
        .i_d4    (r_d4),
        .i_x     (w_xo),
        .i_y     (w_yo),
        .i_flip  (w_fo),
        .o_pos_x (o_pos_x),
        .o_pos_y (o_pos_y),
        .o_pos_z (o_pos_z)
    );

endmodule

// File: hw/rtl/fk3_checker.sv
// ----------------------------------------------------------------------------
// fk3_checker: port-level checks for the arm kinematics block
// Watches the handshakes on the top-level ports.
// ----------------------------------------------------------------------------
module fk3_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [fk3_pkg::POS_W-1:0]  o_pos_x,
    input  logic signed [fk3_pkg::POS_W-1:0]  o_pos_y,
    input  logic signed [fk3_pkg::POS_W-1:0]  o_pos_z
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_pos_z))
        else $error("output item changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input is taken whenever no result is waiting
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // a stalled output freezes the input side
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    // an offered input item stays offered until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid)
        else $error("input item withdrawn before accept");

endmodule

bind arm_forward_kinematics_3axis fk3_checker u_fk3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pos_x     (o_pos_x),
    .o_pos_y     (o_pos_y),
    .o_pos_z     (o_pos_z)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for arm_forward_kinematics_3axis
// Streams joint-angle triples through the arm kinematics pipeline under
// random sender bursts and receiver stalls, predicts each tool position with
// a bit-exact CORDIC model and checks every position field in order. Link
// lengths are changed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
    import fk3_pkg::*;

    localparam int PIPE_LAT  = 3 + CORDIC_STAGES + 5;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic signed [ANG_W-1:0] base;
        logic signed [ANG_W-1:0] shoulder;
        logic signed [ANG_W-1:0] elbow;
    } joint_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } tool_pos_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [ANG_W-1:0] i_base_angle = '0;
    logic signed [ANG_W-1:0] i_shoulder_angle = '0;
    logic signed [ANG_W-1:0] i_elbow_angle = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;
    logic signed [POS_W-1:0] o_pos_z;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    // link lengths as the block should hold them (mm)
    longint link_a1 = 150, link_a2 = 570, link_a3 = 130, link_d4 = 640;

    joint_t    joint_q[$];
    tool_pos_t pos_q[$];
    int        errors = 0;
    int        cycles = 0;

    // sender and receiver shaping, changed per phase
    bit           send_steady = 1'b0;
    bit           recv_steady = 1'b0;
    int           burst_left = 1;
    int           gap_left = 0;
    logic [15:0]  stall_pat = 16'hFFFF;

    arm_forward_kinematics_3axis dut (.*);

    always #2 i_clk = ~i_clk;

    // ---- position predictor ----

    // hundredths of a degree to binary angle, full turn = 2^32
    function automatic logic [31:0] angle_to_bam(longint h);
        longint m;
        longint unsigned num;
        m = h % TURN;
        if (m < 0)
            m += TURN;
        num = ($unsigned(m) << 32) + 64'd18000;
        return 32'(num / 64'd36000);
    endfunction

    // rotation CORDIC with half-turn folding; Q30 results
    function automatic void cordic_sin_cos(input logic [31:0] ang,
                                           output longint c, output longint s);
        logic [31:0] t;
        bit          flip;
        longint      x, y, z, nx;
        t    = ang;
        flip = (t[31:30] == 2'b01) || (t[31:30] == 2'b10);
        if (flip)
            t = t + 32'h8000_0000;
        z = longint'($signed(t));
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'({32'b0, ATAN_BAM[i]});
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'({32'b0, ATAN_BAM[i]});
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v > 262143)
            return POS_MAX;
        if (v < -262144)
            return POS_MIN;
        return v[POS_W-1:0];
    endfunction

    function automatic tool_pos_t arm_position(joint_t j);
        longint cs, ss, c2, s2, c23, s23, rq, r16, zq;
        tool_pos_t p;
        cordic_sin_cos(angle_to_bam(longint'(j.base)), cs, ss);
        cordic_sin_cos(angle_to_bam(longint'(j.shoulder)), c2, s2);
        cordic_sin_cos(angle_to_bam(longint'(j.shoulder) + longint'(j.elbow)), c23, s23);
        rq  = link_a3 * c23 - link_d4 * s23 + link_a2 * c2 + (link_a1 <<< 30);
        r16 = (rq + (longint'(1) <<< 13)) >>> 14;
        zq  = -link_a3 * s23 - link_d4 * c23 - link_a2 * s2;
        p.x = clamp_pos((cs * r16 + (longint'(1) <<< 41)) >>> 42);
        p.y = clamp_pos((ss * r16 + (longint'(1) <<< 41)) >>> 42);
        p.z = clamp_pos((zq + (longint'(1) <<< 25)) >>> 26);
        return p;
    endfunction

    // ---- item driver: bursts with random gaps ----
    always @(posedge i_clk) begin
        joint_t nxt;
        bit     fire;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                pos_q.push_back(arm_position({i_base_angle, i_shoulder_angle,
                                              i_elbow_angle}));
            if (!i_in_valid || o_in_ready) begin
                fire = 1'b0;
                if (gap_left > 0 && !send_steady)
                    gap_left--;
                else if (joint_q.size() > 0) begin
                    fire = 1'b1;
                    nxt  = joint_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                i_in_valid <= fire;
                if (fire) begin
                    i_base_angle     <= nxt.base;
                    i_shoulder_angle <= nxt.shoulder;
                    i_elbow_angle    <= nxt.elbow;
                end
            end
        end
    end

    // ---- receiver stall pattern ----
    always @(posedge i_clk) begin
        stall_pat   <= {stall_pat[14:0], stall_pat[15]};
        i_out_ready <= recv_steady | stall_pat[15];
    end

    // ---- result monitor ----
    always @(posedge i_clk) begin
        tool_pos_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pos_q.size() == 0) begin
                $error("position item with nothing expected: x=%0d y=%0d z=%0d",
                       o_pos_x, o_pos_y, o_pos_z);
                errors++;
            end else begin
                want = pos_q.pop_front();
                if (o_pos_x !== want.x) begin
                    $error("pos_x expected %0d actual %0d", want.x, o_pos_x);
                    errors++;
                end
                if (o_pos_y !== want.y) begin
                    $error("pos_y expected %0d actual %0d", want.y, o_pos_y);
                    errors++;
                end
                if (o_pos_z !== want.z) begin
                    $error("pos_z expected %0d actual %0d", want.z, o_pos_z);
                    errors++;
                end
            end
        end
    end

    // ---- run limit ----
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLE) begin
            $display("timeout with %0d items outstanding", pos_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_link(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_BASE_OFFSET:  link_a1 = val;
            REG_UPPER_ARM:    link_a2 = val;
            REG_ELBOW_OFFSET: link_a3 = val;
            REG_FOREARM:      link_d4 = val;
            default: ;
        endcase
    endtask

    task automatic set_links(int a1, int a2, int a3, int d4);
        write_link(REG_BASE_OFFSET, CFG_W'(a1));
        write_link(REG_UPPER_ARM, CFG_W'(a2));
        write_link(REG_ELBOW_OFFSET, CFG_W'(a3));
        write_link(REG_FOREARM, CFG_W'(d4));
    endtask

    task automatic add_joint(int s, int l, int u);
        joint_t j;
        j.base     = ANG_W'(s);
        j.shoulder = ANG_W'(l);
        j.elbow    = ANG_W'(u);
        joint_q.push_back(j);
    endtask

    // in-range angles half the time, some near quadrant edges, some raw 17-bit
    function automatic int rand_angle();
        case ($urandom_range(0, 5))
            0, 1:    return int'($signed(ANG_W'($urandom_range(0, 131071))));
            2:       return 9000 * $urandom_range(0, 8) - 36000 + $urandom_range(0, 4) - 2;
            default: return $urandom_range(0, 72000) - 36000;
        endcase
    endfunction

    task automatic add_random(int n);
        repeat (n) add_joint(rand_angle(), rand_angle(), rand_angle());
    endtask

    // let the queue drain and the pipeline empty
    task automatic drain();
        wait (joint_q.size() == 0 && !i_in_valid && pos_q.size() == 0);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    task automatic shape_phase();
        send_steady = ($urandom_range(0, 3) == 0);
        recv_steady = ($urandom_range(0, 3) == 0);
        stall_pat   = 16'($urandom) | 16'h0101;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset link lengths, angle extremes and quadrant edges
        shape_phase();
        add_joint(0, 0, 0);
        add_joint(-65536, -65536, -65536);
        add_joint(65535, 65535, 65535);
        add_joint(36000, -36000, 36000);
        add_joint(9000, 9000, 0);
        add_joint(18000, 18000, 0);
        add_joint(27000, 27000, 0);
        add_joint(-9000, -9000, 0);
        add_joint(8999, 9001, -1);
        add_joint(26999, 27001, 1);
        add_joint(17999, 0, 18001);
        add_joint(1, -1, 9000);
        add_joint(4500, -4500, -27000);
        add_joint(35999, 35999, 35999);
        add_joint(65535, -65536, 65535);
        add_joint(-36001, 36001, -18000);
        add_random(150);
        drain();

        // all links at maximum: reach and height stay within the position range
        set_links(4095, 4095, 4095, 4095);
        write_link(8'd4, 12'hFFF);
        shape_phase();
        add_joint(0, 0, 0);
        add_joint(0, 9000, 0);
        add_joint(9000, 27000, 0);
        add_joint(18000, 0, 9000);
        add_random(120);
        drain();

        // all links zero
        set_links(0, 0, 0, 0);
        shape_phase();
        add_joint(0, 0, 0);
        add_joint(65535, -65536, 65535);
        add_random(60);
        drain();

        // random geometries, stray register indexes written in between
        repeat (6) begin
            set_links($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 1000), $urandom_range(0, 4095));
            write_link(8'($urandom_range(4, 255)), CFG_W'($urandom));
            shape_phase();
            add_random(110);
            drain();
        end

        // back to the nominal arm
        set_links(150, 570, 130, 640);
        shape_phase();
        add_random(100);
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/fk3_pkg.sv
hw/rtl/fk3_bam.sv
hw/rtl/fk3_cell.sv
hw/rtl/fk3_post.sv
hw/rtl/arm_forward_kinematics_3axis.sv
hw/rtl/fk3_checker.sv
dv/tb_top.sv
